@@ design/fpt_pkg.sv @@
`timescale 1ns / 1ps

package fpt_pkg;

  // Field widths
  localparam int unsigned CLOCK_W  = 48;   // 32.16 deadline clock, wraps mod 2^48
  localparam int unsigned PERIOD_W = 47;
  localparam int unsigned AHEAD_W  = 4;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned LATE_W   = 31;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = PERIOD_W;

  // Tick rate covers 1e6 .. 1e9, so 30 bits always hold it
  localparam int unsigned TPS_W = 30;
  localparam int unsigned TICKS_PER_SEC_DEF = 46875000;
  localparam int unsigned MICROS_PER_SEC = 1000000;
  localparam int unsigned MICROS_W = 20;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 47'd51539607552;

  typedef enum logic [1:0] {
    CMD_START     = 2'd0,
    CMD_FRAME_END = 2'd1,
    CMD_QUERY     = 2'd2
  } command_e;

  typedef enum logic [1:0] {
    ST_ON_TIME = 2'd0,
    ST_WAIT    = 2'd1,
    ST_LATE    = 2'd2,
    ST_DONE    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD = 2'd0,
    CFG_SKIP   = 2'd1,
    CFG_AHEAD  = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [TICK_W-1:0] tick_now;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [LATE_W-1:0]        late_micros;
    logic [TICK_W-1:0]        wait_until;
    logic signed [TICK_W-1:0] time_left;
    logic [TICK_W-1:0]        frame_length;
  } result_t;

  // Core stage output: result with late_micros still zero, plus lateness in ticks
  typedef struct packed {
    result_t           res;
    logic [LATE_W-1:0] late_ticks;
  } core_out_t;

  // a is before b when (a - b), read as signed, is negative
  function automatic logic tick_before(input logic [TICK_W-1:0] a,
                                       input logic [TICK_W-1:0] b);
    logic [TICK_W-1:0] diff;
    diff = a - b;
    return diff[TICK_W-1];
  endfunction

endpackage

@@ design/fpt_core.sv @@
`timescale 1ns / 1ps

module fpt_core (
  input  logic [fpt_pkg::CLOCK_W-1:0]  clock_q,
  input  logic [fpt_pkg::PERIOD_W-1:0] period,
  input  logic                         skip,
  input  logic [fpt_pkg::AHEAD_W-1:0]  ahead,
  input  fpt_pkg::item_t               item,
  output logic [fpt_pkg::CLOCK_W-1:0]  clock_next,
  output fpt_pkg::core_out_t           core_out
);
  import fpt_pkg::*;

  logic [CLOCK_W-1:0] advanced;
  logic [CLOCK_W-1:0] resync;
  logic [CLOCK_W-1:0] back;
  logic [CLOCK_W-1:0] target_fx;
  logic [TICK_W-1:0]  prev_tick;
  logic [TICK_W-1:0]  next_tick;
  logic [TICK_W-1:0]  target;
  logic [TICK_W-1:0]  late_diff;
  logic [PERIOD_W+AHEAD_W-1:0] back_full;

  assign advanced  = clock_q + {1'b0, period};
  assign resync    = {item.tick_now, {FRAC_W{1'b0}}};
  assign prev_tick = clock_q[CLOCK_W-1:FRAC_W];
  assign next_tick = advanced[CLOCK_W-1:FRAC_W];
  assign late_diff = item.tick_now - prev_tick;
  // 47 x 4 product: four shifted adds at most
  assign back_full = period * ahead;
  assign back      = back_full[CLOCK_W-1:0];
  assign target_fx = advanced - back;
  assign target    = target_fx[CLOCK_W-1:FRAC_W];

  always_comb begin
    clock_next                    = clock_q;
    core_out.res.status           = ST_DONE;
    core_out.res.late_micros      = '0;
    core_out.res.wait_until       = '0;
    core_out.res.time_left        = '0;
    core_out.res.frame_length     = {1'b0, period[PERIOD_W-1:FRAC_W]};
    core_out.late_ticks           = '0;
    unique case (item.command)
      CMD_START: begin
        clock_next = resync;
      end
      CMD_FRAME_END: begin
        if (!tick_before(item.tick_now, next_tick)) begin
          // late: saturate a negative lateness at zero
          core_out.late_ticks = late_diff[TICK_W-1] ? '0 : late_diff[LATE_W-1:0];
          clock_next          = skip ? advanced : resync;
          core_out.res.status = ST_LATE;
        end else begin
          clock_next = advanced;
          if (tick_before(item.tick_now, target)) begin
            core_out.res.status     = ST_WAIT;
            core_out.res.wait_until = target;
          end else begin
            core_out.res.status = ST_ON_TIME;
          end
        end
      end
      default: begin
        // query, and the spare code behaves the same
        core_out.res.time_left = next_tick - item.tick_now;
      end
    endcase
  end

endmodule

@@ design/frame_pacing_throttle.sv @@
`timescale 1ns / 1ps

// Channel   Handshake              Payload                    Direction
// item      item_valid/item_stall  command, tick_now          in
// result    result_valid/result_stall  status .. frame_length out
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data        in
//
// Items pass the input, stage and output registers in order; one item per
// cycle sustained while result_stall is low. The deadline clock updates in
// the cycle an item leaves the input register, so the next item sees it at once.
// The tick-to-microsecond conversion is a three-stage multiply pipeline.
// Reset (rst, synchronous) empties every stage and restores register defaults.
// Stalls collapse bubbles: each stage loads whenever it is empty or draining.
module frame_pacing_throttle #(
  parameter int unsigned TICKS_PER_SEC = fpt_pkg::TICKS_PER_SEC_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  fpt_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output fpt_pkg::result_t               result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpt_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fpt_pkg::*;

  // floor(2^32 * 1e6 / TICKS_PER_SEC); needs 33 bits at the slowest tick rate
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << 32) * 64'(MICROS_PER_SEC)) / 64'(TICKS_PER_SEC);
  localparam logic [32:0] RECIP = RECIP_FULL[32:0];
  localparam logic [TPS_W-1:0] TPS = TPS_W'(TICKS_PER_SEC);
  localparam int unsigned NUM_W = LATE_W + MICROS_W;
  localparam int unsigned QT_W  = LATE_W + TPS_W;

  // Configuration registers
  logic [PERIOD_W-1:0] frame_period_fx;
  logic                skip_allowed;
  logic [AHEAD_W-1:0]  frames_ahead;

  // Deadline clock state
  logic [CLOCK_W-1:0] deadline_clock;
  logic [CLOCK_W-1:0] clock_next;

  // Stage valids and payloads
  logic v0, v1, v2, v3, v4;
  logic free0, free1, free2, free3, free4;
  item_t             s0_item;
  core_out_t         core_out;
  result_t           s1_res, s2_res, s3_res;
  result_t           result_next;
  logic [LATE_W-1:0] s1_late;
  logic [LATE_W-1:0] s2_q0, s3_q0;
  logic [NUM_W-1:0]  s2_num, s3_num;
  logic [QT_W-1:0]   s3_qt;
  logic [63:0]       prod_full;
  logic [NUM_W-1:0]  num_full;
  logic [QT_W-1:0]   qt_full;
  logic [NUM_W:0]    rem;
  logic [LATE_W-1:0] late_q;
  logic              move01;

  // Register writes; always ready; writes must come only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_period_fx <= PERIOD_RESET;
      skip_allowed    <= 1'b0;
      frames_ahead    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PERIOD: frame_period_fx <= cfg_data;
        CFG_SKIP:   skip_allowed    <= cfg_data[0];
        CFG_AHEAD:  frames_ahead    <= cfg_data[AHEAD_W-1:0];
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Bubble-collapsing flow control: a stage loads when empty or when its
  // content moves on in the same cycle.
  assign free4 = !v4 || !result_stall;
  assign free3 = !v3 || free4;
  assign free2 = !v2 || free3;
  assign free1 = !v1 || free2;
  assign free0 = !v0 || free1;
  assign item_stall = !free0;
  assign move01 = v0 && free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (free0) v0 <= item_valid;
      if (free1) v1 <= v0;
      if (free2) v2 <= v1;
      if (free3) v3 <= v2;
      if (free4) v4 <= v3;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (free0) s0_item <= item;
  end

  fpt_core u_core (
    .clock_q    (deadline_clock),
    .period     (frame_period_fx),
    .skip       (skip_allowed),
    .ahead      (frames_ahead),
    .item       (s0_item),
    .clock_next (clock_next),
    .core_out   (core_out)
  );

  // Advance the deadline clock only as an item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      deadline_clock <= '0;
    end else if (move01) begin
      deadline_clock <= clock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      s1_res  <= core_out.res;
      s1_late <= core_out.late_ticks;
    end
  end

  // Lateness to microseconds: q0 = (d * RECIP) >> 32 is the true quotient or
  // one below it; the remainder check adds the missing one.
  assign prod_full = {33'b0, s1_late} * {31'b0, RECIP};
  assign num_full  = {{MICROS_W{1'b0}}, s1_late} * NUM_W'(MICROS_PER_SEC);

  always_ff @(posedge clk) begin
    if (free2) begin
      s2_res <= s1_res;
      s2_q0  <= prod_full[32+LATE_W-1:32];
      s2_num <= num_full;
    end
  end

  assign qt_full = {{TPS_W{1'b0}}, s2_q0} * {{LATE_W{1'b0}}, TPS};

  always_ff @(posedge clk) begin
    if (free3) begin
      s3_res <= s2_res;
      s3_q0  <= s2_q0;
      s3_num <= s2_num;
      s3_qt  <= qt_full;
    end
  end

  assign rem    = {1'b0, s3_num} - {1'b0, s3_qt[NUM_W-1:0]};
  assign late_q = (rem >= (NUM_W+1)'(TPS)) ? s3_q0 + 1'b1 : s3_q0;

  // Merge the converted lateness into the result
  always_comb begin
    result_next             = s3_res;
    result_next.late_micros = late_q;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (free4) result <= result_next;
  end

  assign result_valid = v4;

  // Empty pipeline right after reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A start loads the clock from the tick it carried
  assert property (@(posedge clk) disable iff (rst)
    move01 && s0_item.command == CMD_START |=>
      deadline_clock == {$past(s0_item.tick_now), {FRAC_W{1'b0}}})
    else $error("start did not load the deadline clock");

  // Lateness shows only on late results
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_LATE |-> result.late_micros == '0)
    else $error("lateness on a result that is not late");

  // Only a wait result carries a target tick
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_WAIT |-> result.wait_until == '0)
    else $error("wait target on a result that does not wait");

  // The deadline clock holds unless an item leaves the input register
  assert property (@(posedge clk) disable iff (rst)
    !move01 |=> $stable(deadline_clock))
    else $error("deadline clock moved without an item");

endmodule
